/* rtl/smtm_pkg.sv */
package smtm_pkg;

  localparam int unsigned DataW          = 16;
  localparam int unsigned WindowSizeDef  = 16;
  localparam int unsigned CenterTaps     = 5;
  // Sum of five 16-bit values fits in 19 bits.
  localparam int unsigned SumW           = 19;
  // floor(s / 5) == (s * 419431) >> 21 for every s below 2^19.
  localparam int unsigned RecipW         = 19;
  localparam logic [RecipW-1:0] Recip5   = 19'd419431;
  localparam int unsigned RecipShift     = 21;
  localparam int unsigned ProdW          = SumW + RecipW;

  // Handed from cell i to cell i+1: the value cell i holds once the oldest
  // entry is taken out, and whether that value ranks below the new sample.
  typedef struct packed {
    logic [DataW-1:0] w;
    logic             lt;
  } smtm_link_t;

endpackage

/* rtl/smtm_ram.sv */
module smtm_ram #(
  parameter int unsigned Width = 16,
  parameter int unsigned Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

/* rtl/smtm_cell.sv */
module smtm_cell (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           en_i,
  input  logic [smtm_pkg::DataW-1:0]     sample_i,
  input  logic [smtm_pkg::DataW-1:0]     old_i,
  input  logic [smtm_pkg::DataW-1:0]     v_up_i,
  input  smtm_pkg::smtm_link_t           link_i,
  output smtm_pkg::smtm_link_t           link_o,
  output logic [smtm_pkg::DataW-1:0]     v_o
);
  import smtm_pkg::*;

  logic [DataW-1:0] v_q, v_d;
  logic [DataW-1:0] w;
  logic             lt;

  // Entries below the deleted one stay, entries above it move down one.
  assign w  = (v_q < old_i) ? v_q : v_up_i;
  assign lt = (w < sample_i);

  // Below the insertion point keep w, at it take the sample, above it
  // take the neighbor's w.
  always_comb begin
    if (lt) begin
      v_d = w;
    end else if (link_i.lt) begin
      v_d = sample_i;
    end else begin
      v_d = link_i.w;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (en_i) begin
      v_q <= v_d;
    end
  end

  assign link_o.w  = w;
  assign link_o.lt = lt;
  assign v_o       = v_q;

endmodule

/* rtl/sliding_median_trimmed_mean_top.sv */
// Sliding-window trimmed-mean filter.
// Request channel: sample_i with sample_valid_i / sample_ready_o. Each request
// replaces the oldest of WINDOW_SIZE stored samples. Result channel: filtered_o
// with filtered_valid_o / filtered_ready_i; one result per request, equal to
// the truncated mean of the five central ranked samples of the window.
// The window is kept sorted in a row of cells; each request shifts the row
// as a whole, deleting the oldest value (read from a ring buffer) and
// inserting the new one. Then the five center cells are summed, and the sum
// is divided by five with a reciprocal multiply.
// filtered_valid_o rises once the accepted request has passed the read,
// sum and multiply states and the output load. No new request is taken
// until the last one has walked through the accept, the ring-buffer read
// with the cell update, the sum, the multiply and the output load.
// sample_ready_o is high whenever the block is idle, even while a result
// waits; if the receiver stalls, the next request stops before the output
// register until the waiting result is taken.
// Reset: the window reads as all zeros and the write position is zero, so
// early results include those zeros; the output register is emptied.
module sliding_median_trimmed_mean_top #(
  parameter int unsigned WINDOW_SIZE = smtm_pkg::WindowSizeDef
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       sample_valid_i,
  output logic                       sample_ready_o,
  input  logic [smtm_pkg::DataW-1:0] sample_i,
  output logic                       filtered_valid_o,
  input  logic                       filtered_ready_i,
  output logic [smtm_pkg::DataW-1:0] filtered_o
);
  import smtm_pkg::*;

  localparam int unsigned PosW = $clog2(WINDOW_SIZE);
  localparam int unsigned Mid  = WINDOW_SIZE / 2;

  typedef enum logic [2:0] {
    S_IDLE,
    S_READ,   // ring-buffer read data arrives, cells update
    S_SUM,    // add the five center cells
    S_MUL,    // reciprocal multiply
    S_OUT     // load the output register once it is free
  } state_e;

  state_e state_q;

  logic [PosW-1:0]        pos_q, pos_nxt;
  logic [WINDOW_SIZE-1:0] filled_q;   // ring entry written since reset
  logic [DataW-1:0]       sample_q;
  logic [SumW-1:0]        sum_q, sum_d;
  logic [ProdW-1:0]       prod_q;
  logic                   filtered_valid_q;
  logic [DataW-1:0]       filtered_q;

  logic [DataW-1:0]       ram_rdata;
  logic [DataW-1:0]       old_val;
  logic                   accept;
  logic                   cell_en;

  assign accept  = sample_valid_i && (state_q == S_IDLE);
  assign cell_en = (state_q == S_READ);
  assign pos_nxt = (pos_q == PosW'(WINDOW_SIZE - 1)) ? '0 : pos_q + 1'b1;

  // Ring buffer: read the entry about to be overwritten, write the new sample
  // in the following cycle. Entries never written read as zero.
  smtm_ram #(
    .Width (DataW),
    .Depth (WINDOW_SIZE)
  ) u_ring (
    .clk_i   (clk_i),
    .we_i    (cell_en),
    .waddr_i (pos_q),
    .wdata_i (sample_q),
    .raddr_i (pos_nxt),
    .rdata_o (ram_rdata)
  );

  assign old_val = filled_q[pos_q] ? ram_rdata : '0;

  // Sorted row of cells, ascending from index 0.
  smtm_link_t       link [WINDOW_SIZE+1];
  logic [DataW-1:0] vals [WINDOW_SIZE+1];

  // The bottom cell always sees "insert here" from below; the top cell sees
  // an all-ones neighbor so nothing ranks above it.
  assign link[0].w  = '0;
  assign link[0].lt = 1'b1;
  assign vals[WINDOW_SIZE] = '1;

  for (genvar i = 0; i < WINDOW_SIZE; i++) begin : g_cell
    smtm_cell u_cell (
      .clk_i    (clk_i),
      .rst_ni   (rst_ni),
      .en_i     (cell_en),
      .sample_i (sample_q),
      .old_i    (old_val),
      .v_up_i   (vals[i+1]),
      .link_i   (link[i]),
      .link_o   (link[i+1]),
      .v_o      (vals[i])
    );
  end

  assign sum_d = SumW'(vals[Mid-2]) + SumW'(vals[Mid-1]) + SumW'(vals[Mid])
               + SumW'(vals[Mid+1]) + SumW'(vals[Mid+2]);

  // Datapath registers, no reset needed.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      sample_q <= sample_i;
    end
    if (state_q == S_SUM) begin
      sum_q <= sum_d;
    end
    if (state_q == S_MUL) begin
      prod_q <= ProdW'(sum_q) * ProdW'(Recip5);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q          <= S_IDLE;
      pos_q            <= '0;
      filled_q         <= '0;
      filtered_valid_q <= 1'b0;
      filtered_q       <= '0;
    end else begin
      if (filtered_valid_q && filtered_ready_i) begin
        filtered_valid_q <= 1'b0;
      end
      unique case (state_q)
        S_IDLE: begin
          if (sample_valid_i) begin
            pos_q   <= pos_nxt;
            state_q <= S_READ;
          end
        end
        S_READ: begin
          filled_q[pos_q] <= 1'b1;
          state_q         <= S_SUM;
        end
        S_SUM: begin
          state_q <= S_MUL;
        end
        S_MUL: begin
          state_q <= S_OUT;
        end
        S_OUT: begin
          if (!filtered_valid_q || filtered_ready_i) begin
            filtered_valid_q <= 1'b1;
            filtered_q       <= prod_q[RecipShift +: DataW];
            state_q          <= S_IDLE;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  assign sample_ready_o   = (state_q == S_IDLE);
  assign filtered_valid_o = filtered_valid_q;
  assign filtered_o       = filtered_q;

endmodule

/* verif/tb_sliding_median_trimmed_mean_top.sv */
`timescale 1ns / 1ps

module tb_sliding_median_trimmed_mean_top;

  localparam int unsigned DataW      = smtm_pkg::DataW;
  localparam int unsigned WindowLen  = smtm_pkg::WindowSizeDef;
  localparam int unsigned CenterLen  = smtm_pkg::CenterTaps;
  // Block walks each request through the read, sum, multiply and output states; pad generously.
  localparam int unsigned TailCycles = 16;
  // ~2000 requests plus heavy idling stays far below this.
  localparam int unsigned CycleLimit = 400000;
  localparam int unsigned PhaseLen   = 490;

  logic             clk_i = 1'b0;
  logic             rst_ni;
  logic             sample_valid_i;
  logic             sample_ready_o;
  logic [DataW-1:0] sample_i;
  logic             filtered_valid_o;
  logic             filtered_ready_i;
  logic [DataW-1:0] filtered_o;

  // Window mirror: same ring order as the block, zero after reset.
  logic [DataW-1:0] window_mirror [WindowLen];
  int unsigned      newest_slot;

  // Trimmed means still owed by the block, oldest first.
  logic [DataW-1:0] owed_means_q [$];

  int unsigned mismatch_count;
  int unsigned cycle_count;
  int unsigned request_idle_pct;
  int unsigned result_stall_pct;
  int          noise_level;

  sliding_median_trimmed_mean_top u_dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .sample_valid_i   (sample_valid_i),
    .sample_ready_o   (sample_ready_o),
    .sample_i         (sample_i),
    .filtered_valid_o (filtered_valid_o),
    .filtered_ready_i (filtered_ready_i),
    .filtered_o       (filtered_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Hard stop if the block hangs.
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CycleLimit) begin
      $display("sliding_median_trimmed_mean_top: mismatch");
      $finish;
    end
  end

  task automatic report_mismatch(input string what);
    $display("ERROR @%0t: %s", $realtime, what);
    mismatch_count++;
  endtask

  // Overwrite the oldest slot, rank the window, average the five center ranks.
  // Position advances before the write, so the first sample lands in slot 1.
  function automatic logic [DataW-1:0] insert_and_trim(input logic [DataW-1:0] sample);
    logic [DataW-1:0] ranked [WindowLen];
    logic [DataW-1:0] key;
    int               j;
    int unsigned      center_sum;
    newest_slot = (newest_slot + 1) % WindowLen;
    window_mirror[newest_slot] = sample;
    for (int i = 0; i < WindowLen; i++) ranked[i] = window_mirror[i];
    // insertion sort, ascending; tie order is irrelevant to the result
    for (int i = 1; i < WindowLen; i++) begin
      key = ranked[i];
      j   = i;
      while (j > 0 && ranked[j-1] > key) begin
        ranked[j] = ranked[j-1];
        j--;
      end
      ranked[j] = key;
    end
    center_sum = 0;
    for (int k = WindowLen/2 - 2; k <= WindowLen/2 + 2; k++) center_sum += ranked[k];
    return DataW'(center_sum / CenterLen);
  endfunction

  // Result side: random stalls on ready, one nonblocking write per edge.
  // Each accepted result is checked against the oldest owed mean.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (filtered_valid_o && filtered_ready_i) begin
        if (owed_means_q.size() == 0) begin
          report_mismatch($sformatf("unexpected result filtered=%0d", filtered_o));
        end else if (filtered_o !== owed_means_q[0]) begin
          report_mismatch($sformatf("filtered=%0d, want %0d", filtered_o, owed_means_q[0]));
          void'(owed_means_q.pop_front());
        end else begin
          void'(owed_means_q.pop_front());
        end
      end
    end
    filtered_ready_i <= ($urandom_range(99) >= result_stall_pct);
  end

  // Send one request. Entered at an edge; on return the request was just
  // accepted and valid is still high, so the caller must either send again in
  // the same step or call wait_drained, which lowers valid.
  task automatic send_sample(input logic [DataW-1:0] value);
    while ($urandom_range(99) < request_idle_pct) begin
      sample_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    sample_valid_i <= 1'b1;
    sample_i       <= value;
    do @(posedge clk_i); while (!sample_ready_o);
    owed_means_q.push_back(insert_and_trim(value));
  endtask

  // Drop valid, wait for every owed result, then let the pipe settle.
  task automatic wait_drained();
    sample_valid_i <= 1'b0;
    while (owed_means_q.size() != 0) @(posedge clk_i);
    repeat (TailCycles) @(posedge clk_i);
  endtask

  // Sensor-like values: wide noise, a wandering level with small jitter,
  // rail values and single-bit spikes off the level.
  function automatic logic [DataW-1:0] pick_sample();
    int unsigned mode;
    int          v;
    mode = $urandom_range(99);
    if ($urandom_range(99) < 4) noise_level = $urandom_range(65535);
    if (mode < 35) begin
      v = $urandom_range(65535);
    end else if (mode < 65) begin
      v = noise_level + $urandom_range(128) - 64;
      if (v < 0) v = 0;
      if (v > 65535) v = 65535;
    end else if (mode < 80) begin
      case ($urandom_range(3))
        0:       v = 0;
        1:       v = 1;
        2:       v = 65534;
        default: v = 65535;
      endcase
    end else begin
      v = noise_level ^ (1 << $urandom_range(DataW - 1));
    end
    return DataW'(v);
  endfunction

  // Start-up: a few full-scale samples among reset zeros still give zero.
  task automatic test_startup_zeros();
    repeat (3) send_sample('1);
  endtask

  // Fill the whole window at full scale: the mean reaches the top of range,
  // and the write position wraps past the last slot.
  task automatic test_full_scale();
    repeat (WindowLen - 3) send_sample('1);
  endtask

  // Ties, the bottom rail and mid-scale bit patterns pushed into the center.
  task automatic test_ties_and_rails();
    send_sample('0);
    send_sample(16'd1);
    send_sample(16'd65534);
    send_sample(16'h8000);
    send_sample(16'h7fff);
    send_sample('0);
  endtask

  task automatic test_random(input int unsigned idle_pct, input int unsigned stall_pct,
                             input bit pause_midway);
    request_idle_pct = idle_pct;
    result_stall_pct = stall_pct;
    for (int n = 0; n < PhaseLen; n++) begin
      // let the block run completely dry once with requests held off
      if (pause_midway && n == PhaseLen / 2) wait_drained();
      send_sample(pick_sample());
    end
    wait_drained();
  endtask

  initial begin
    rst_ni           <= 1'b0;
    sample_valid_i   <= 1'b0;
    sample_i         <= '0;
    filtered_ready_i <= 1'b0;
    mismatch_count   = 0;
    cycle_count      = 0;
    request_idle_pct = 0;
    result_stall_pct = 0;
    noise_level      = 32768;
    newest_slot      = 0;
    for (int i = 0; i < WindowLen; i++) window_mirror[i] = '0;

    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_startup_zeros();
    test_full_scale();
    test_ties_and_rails();
    wait_drained();

    test_random(0, 0, 1'b0);
    test_random(60, 0, 1'b1);
    test_random(0, 60, 1'b0);
    test_random(32, 32, 1'b0);

    if (owed_means_q.size() != 0) begin
      report_mismatch($sformatf("%0d results never arrived", owed_means_q.size()));
    end
    if (mismatch_count == 0) begin
      $display("sliding_median_trimmed_mean_top: match");
    end else begin
      $display("sliding_median_trimmed_mean_top: mismatch");
    end
    $finish;
  end

endmodule
